>>> rtl/kwsm_pkg.sv
// ============================================================================
// kwsm_pkg: shared types and constants of the k-way sorted merge block
// Holds the sequencer state encoding, the input function codes and the fixed
// field widths of the stream payloads.
// ============================================================================
`default_nettype none

package kwsm_pkg;

    // Fixed payload widths.
    localparam int ValueW  = 32;
    localparam int ListIdW = 2;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // Input function codes carried in tuser.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_MERGE  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/kwsm_ram.sv
// ============================================================================
// kwsm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module kwsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/k_way_sorted_merge.sv
// ============================================================================
// k_way_sorted_merge: merge of up to NUM_LISTS sorted lists by head scan
// Appends go into a shared list memory; a merge command scans the list heads
// with one comparator and streams out the merged order.
// ============================================================================
// An append is accepted while idle and the block stays ready for more input.
// A merge reads the list heads in turn from the one-read-per-cycle list
// memory, compares them in the shared comparator and raises a result once
// the last head is compared; the next scan starts after that result is taken,
// and no input is accepted until the last result is. Reset (synchronous,
// active low) empties all lists and clears the overflow flag, not the memory.
`default_nettype none

module k_way_sorted_merge #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic [2:0]  i_s_tuser,   // [0] func, [2:1] list_id
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // [31:0] value_res
    output logic      [2:0]  o_m_tuser,   // [1:0] source, [2] overflow
    output logic             o_m_tlast
);

    localparam int LW = $clog2(NUM_LISTS);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(NUM_LISTS * LIST_DEPTH);
    localparam int TW = $clog2(NUM_LISTS * LIST_DEPTH + 1);
    localparam int VW = kwsm_pkg::ValueW;

    // Control state.
    kwsm_pkg::t_state r_state;
    logic [CW-1:0]    r_fill [NUM_LISTS];
    logic [CW-1:0]    r_head [NUM_LISTS];
    logic [TW-1:0]    r_total;     // elements still to be emitted
    logic             r_drop;      // sticky overflow
    logic [LW-1:0]    r_iss;       // list whose head is being read
    logic             r_issuing;
    logic             r_cmp_pend;  // read data of list r_cmp_idx arrives now
    logic             r_cmp_vld;   // that list still had an element
    logic             r_found;

    // Payload.
    logic [LW-1:0]    r_cmp_idx;
    logic [VW-1:0]    r_best;
    logic [LW-1:0]    r_pick;
    logic [VW-1:0]    r_out_value;
    logic [kwsm_pkg::ListIdW-1:0] r_out_src;
    logic             r_out_last;
    logic             r_out_ovf;

    // Input decode.
    logic                         s_accept;
    logic                         s_func;
    logic [kwsm_pkg::ListIdW-1:0] s_lid;
    logic                         lid_ok;
    logic [LW-1:0]                lid_idx;
    logic [LW-1:0]                fill_idx;
    logic [CW-1:0]                fill_sel;
    logic [CW-1:0]                head_sel;
    logic                         list_full;
    logic                         app_write;
    logic                         app_drop;

    // Memory ports.
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [VW-1:0] rd_data;

    // Shared comparator.
    logic          take;
    logic [VW-1:0] nxt_best;
    logic [LW-1:0] nxt_pick;
    logic          scan_done;

    assign o_s_tready = (r_state == kwsm_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign s_func     = i_s_tuser[0];
    assign s_lid      = i_s_tuser[2:1];

    // An append to a list number beyond the configured count is ignored entirely;
    assign lid_ok  = (32'(s_lid) < 32'(NUM_LISTS));
    assign lid_idx = LW'(s_lid);

    // The fill counts are read at a single index: the append target while
    // idle, the list under scan otherwise.
    assign fill_idx  = (r_state == kwsm_pkg::S_IDLE) ? lid_idx : r_iss;
    assign fill_sel  = r_fill[fill_idx];
    assign head_sel  = r_head[r_iss];
    assign list_full = (fill_sel >= CW'(LIST_DEPTH));

    assign app_write = s_accept & (s_func == kwsm_pkg::FUNC_APPEND) & lid_ok & ~list_full;
    assign app_drop  = s_accept & (s_func == kwsm_pkg::FUNC_APPEND) & lid_ok & list_full;

    // List i occupies the memory rows i*LIST_DEPTH onward.
    assign wr_addr = AW'(32'(lid_idx) * LIST_DEPTH + 32'(fill_sel));
    assign rd_en   = (r_state == kwsm_pkg::S_SCAN) & r_issuing;
    assign rd_addr = AW'(32'(r_iss) * LIST_DEPTH + 32'(head_sel));

    kwsm_ram #(
        .WIDTH (VW),
        .DEPTH (NUM_LISTS * LIST_DEPTH)
    ) u_list_ram (
        .i_clk     (i_clk),
        .i_wr_en   (app_write),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // A head replaces the running minimum only when strictly smaller, so on
    // equal values the lower list number, scanned first, is kept.
    assign take      = r_cmp_pend & r_cmp_vld &
                       (~r_found | ($signed(rd_data) < $signed(r_best)));
    assign nxt_best  = take ? rd_data : r_best;
    assign nxt_pick  = take ? r_cmp_idx : r_pick;
    assign scan_done = r_cmp_pend & (r_cmp_idx == LW'(NUM_LISTS - 1));

    // Sequencer and list bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kwsm_pkg::S_IDLE;
            r_total    <= '0;
            r_drop     <= 1'b0;
            r_iss      <= '0;
            r_issuing  <= 1'b0;
            r_cmp_pend <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_fill[i] <= '0;
                r_head[i] <= '0;
            end
        end else begin
            unique case (r_state)
                kwsm_pkg::S_IDLE: begin
                    if (app_write) begin
                        r_fill[lid_idx] <= fill_sel + CW'(1);
                        r_total         <= r_total + TW'(1);
                    end else if (app_drop) begin
                        r_drop <= 1'b1;
                    end else if (s_accept && s_func == kwsm_pkg::FUNC_MERGE) begin
                        if (r_total == '0) begin
                            // Nothing to merge: just clear the lists and flag.
                            r_drop <= 1'b0;
                            for (int i = 0; i < NUM_LISTS; i++) begin
                                r_fill[i] <= '0;
                                r_head[i] <= '0;
                            end
                        end else begin
                            r_state    <= kwsm_pkg::S_SCAN;
                            r_iss      <= '0;
                            r_issuing  <= 1'b1;
                            r_cmp_pend <= 1'b0;
                            r_found    <= 1'b0;
                        end
                    end
                end
                kwsm_pkg::S_SCAN: begin
                    r_cmp_pend <= r_issuing;
                    if (r_issuing) begin
                        r_cmp_vld <= (head_sel < fill_sel);
                        if (r_iss == LW'(NUM_LISTS - 1)) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_iss <= r_iss + LW'(1);
                        end
                    end
                    if (take) begin
                        r_found <= 1'b1;
                    end
                    if (scan_done) begin
                        r_state          <= kwsm_pkg::S_EMIT;
                        r_head[nxt_pick] <= r_head[nxt_pick] + CW'(1);
                        r_total          <= r_total - TW'(1);
                        r_cmp_pend       <= 1'b0;
                    end
                end
                kwsm_pkg::S_EMIT: begin
                    if (i_m_tready) begin
                        if (r_out_last) begin
                            // Run finished: empty every list and the flag.
                            r_state <= kwsm_pkg::S_IDLE;
                            r_drop  <= 1'b0;
                            for (int i = 0; i < NUM_LISTS; i++) begin
                                r_fill[i] <= '0;
                                r_head[i] <= '0;
                            end
                        end else begin
                            r_state   <= kwsm_pkg::S_SCAN;
                            r_iss     <= '0;
                            r_issuing <= 1'b1;
                            r_found   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= kwsm_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Comparator pipeline and output register.
    always_ff @(posedge i_clk) begin
        if (r_state == kwsm_pkg::S_SCAN) begin
            if (r_issuing) begin
                r_cmp_idx <= r_iss;
            end
            r_best <= nxt_best;
            r_pick <= nxt_pick;
            if (scan_done) begin
                r_out_value <= nxt_best;
                r_out_src   <= kwsm_pkg::ListIdW'(nxt_pick);
                r_out_last  <= (r_total == TW'(1));
                r_out_ovf   <= r_drop;
            end
        end
    end

    assign o_m_tvalid = (r_state == kwsm_pkg::S_EMIT);
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = {r_out_ovf, r_out_src};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
